// ===== hdl/rpg_pkg.sv =====
// rpg_pkg: payload types and fixed constants for the permutation generator.
// No dependencies; used by every module of the block except rpg_fifo.
`timescale 1ns / 1ps

package rpg_pkg;

    // one input beat
    typedef struct packed {
        logic [31:0] random_word;
        logic        restart;
    } t_in;

    // one result beat
    typedef struct packed {
        logic [9:0] card;
        logic       last;
    } t_out;

    localparam int CARD_COUNT_W   = 11;
    localparam int CARD_COUNT_RST = 1024;

    // table entries carry an epoch tag; tag zero never matches the live epoch
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

endpackage

// ===== hdl/random_permutation_generator_unit.sv =====
// random_permutation_generator_unit: top level of the shuffle block, with the
// length register. Depends on rpg_pkg, rpg_front, rpg_back and rpg_fifo.
`timescale 1ns / 1ps

// Forward Fisher-Yates shuffle of 0..n-1, one card per input beat. Each beat
// brings a random word; the card fixed at the current position comes out, the
// final one of a permutation with last set, after which a fresh permutation
// begins (restart begins one at once). The front takes a beat every cycle
// while full is low, into a four-deep command queue; the back takes commands
// one at a time, paced by the table memory (both entries read, then two
// writes). A result goes through the front register, the command queue, the
// back's read registers and the result queue. After reset, on the 255th table
// clear after reset and on every 254th after that, the block sweeps the tags
// of all MAX_CARDS table entries with full held high. The length register, at
// APB byte address 0, is for the user to write only while idle (not enforced).
module random_permutation_generator_unit #(
    parameter int MAX_CARDS = 1024,
    parameter int RAND_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  rpg_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output rpg_pkg::t_out o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IDX_W = $clog2(MAX_CARDS);
    localparam int CMD_W = 2 * IDX_W + 2;
    localparam int OUT_W = $bits(rpg_pkg::t_out);
    localparam logic REG_CARD_COUNT = 1'b0;

    logic [rpg_pkg::CARD_COUNT_W-1:0] r_card_count;
    logic                             w_sweeping;
    logic                             w_cmd_push, w_cmd_pop, w_cmd_full, w_cmd_empty;
    logic [CMD_W-1:0]                 w_cmd_in, w_cmd_out;
    logic                             w_out_push, w_out_full;
    rpg_pkg::t_out                    w_out_in;
    logic [OUT_W-1:0]                 w_out_head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_count <= rpg_pkg::CARD_COUNT_W'(rpg_pkg::CARD_COUNT_RST);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CARD_COUNT)) begin
            r_card_count <= pwdata[rpg_pkg::CARD_COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CARD_COUNT) ? 32'(r_card_count) : 32'd0;

    rpg_front #(
        .MAX_CARDS (MAX_CARDS),
        .RAND_BITS (RAND_BITS),
        .IDX_W     (IDX_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_item),
        .i_card_count (r_card_count),
        .i_hold       (w_sweeping),
        .i_cmd_full   (w_cmd_full),
        .o_full       (full),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd_in)
    );

    rpg_fifo #(
        .W     (CMD_W),
        .DEPTH (rpg_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty)
    );

    rpg_back #(
        .MAX_CARDS (MAX_CARDS),
        .IDX_W     (IDX_W),
        .CMD_W     (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out       (w_out_in),
        .o_sweeping  (w_sweeping)
    );

    rpg_fifo #(
        .W     (OUT_W),
        .DEPTH (rpg_pkg::OUT_QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_in),
        .i_pop   (pop),
        .o_data  (w_out_head),
        .o_full  (w_out_full),
        .o_empty (empty)
    );

    assign o_result = w_out_head;

`ifndef SYNTHESIS
    // no beat may enter while the table tags are being swept
    a_hold_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweeping |-> full)
        else $error("input accepted during tag sweep");

    // the back only starts a swap when a result slot is free
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result pushed into a full queue");

    // a command is never taken from an empty queue
    a_cmd_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command popped from empty queue");

    // each popped command yields exactly one result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |=> w_out_push)
        else $error("swap did not produce a result");
`endif

endmodule

// ===== hdl/rpg_fifo.sv =====
// rpg_fifo: small register-based queue used between front and back, and on
// the result side. No package dependencies.
`timescale 1ns / 1ps

module rpg_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + (AW+1)'(1);
            2'b01:   n_cnt = r_cnt - (AW+1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/rpg_front.sv =====
// rpg_front: accepts input beats, tracks the position and works out the swap
// partner j. Depends on rpg_pkg; feeds the command queue.
`timescale 1ns / 1ps

module rpg_front #(
    parameter int MAX_CARDS = 1024,
    parameter int RAND_BITS = 32,
    parameter int IDX_W     = $clog2(MAX_CARDS),
    parameter int CMD_W     = 2 * IDX_W + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  rpg_pkg::t_in                        i_item,
    input  logic [rpg_pkg::CARD_COUNT_W-1:0]    i_card_count,
    input  logic                                i_hold,
    input  logic                                i_cmd_full,
    output logic                                o_full,
    output logic                                o_cmd_push,
    output logic [CMD_W-1:0]                    o_cmd
);

    localparam int CNT_W = $clog2(MAX_CARDS + 1);
    localparam int CW    = (CNT_W > rpg_pkg::CARD_COUNT_W) ? CNT_W : rpg_pkg::CARD_COUNT_W;
    localparam int PW    = RAND_BITS + CNT_W;

    typedef struct packed {
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             clr;
        logic             last;
    } t_cmd;

    logic [IDX_W-1:0]     r_pos, n_pos;
    logic                 r_pend_clr, n_pend_clr;
    logic                 r_a_valid;
    logic [IDX_W-1:0]     r_a_i;
    logic [CNT_W-1:0]     r_a_m;
    logic [RAND_BITS-1:0] r_a_r;
    logic                 r_a_clr;
    logic                 r_a_last;

    logic [CW-1:0]    cc;
    logic [CW-1:0]    n_eff;
    logic [CNT_W-1:0] n_cards;
    logic             clr;
    logic [IDX_W-1:0] cur_i;
    logic             cur_last;
    logic [CNT_W-1:0] cur_m;
    logic             accept;
    logic             adv;
    logic [PW-1:0]    prod;
    logic [CNT_W-1:0] offset;
    t_cmd             cmd;

    assign o_full = i_hold || (r_a_valid && i_cmd_full);
    assign accept = i_push && !o_full;
    assign adv    = !r_a_valid || !i_cmd_full;

    // length clamped into 1..MAX_CARDS
    always_comb begin
        cc = CW'(i_card_count);
        if (cc == '0) begin
            n_eff = CW'(1);
        end else if (cc > CW'(MAX_CARDS)) begin
            n_eff = CW'(MAX_CARDS);
        end else begin
            n_eff = cc;
        end
        n_cards = CNT_W'(n_eff);
    end

    // a stale position (length shrunk) restarts like the restart flag
    assign clr      = i_item.restart || (CNT_W'(r_pos) >= n_cards) || r_pend_clr;
    assign cur_i    = clr ? '0 : r_pos;
    assign cur_last = (CNT_W'(cur_i) == n_cards - CNT_W'(1));
    assign cur_m    = n_cards - CNT_W'(cur_i);

    always_comb begin
        n_pos      = r_pos;
        n_pend_clr = r_pend_clr;
        if (accept) begin
            n_pos      = cur_last ? '0 : cur_i + IDX_W'(1);
            n_pend_clr = cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_pend_clr <= 1'b0;
            r_a_valid  <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_pend_clr <= n_pend_clr;
            if (adv) begin
                r_a_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_i    <= cur_i;
            r_a_m    <= cur_m;
            r_a_r    <= i_item.random_word[RAND_BITS-1:0];
            r_a_clr  <= clr;
            r_a_last <= cur_last;
        end
    end

    // floor(r * (n - i) / 2^RAND_BITS) is always below n - i
    assign prod   = PW'(r_a_r) * PW'(r_a_m);
    assign offset = prod[PW-1:RAND_BITS];

    always_comb begin
        cmd.i    = r_a_i;
        cmd.j    = r_a_i + offset[IDX_W-1:0];
        cmd.clr  = r_a_clr;
        cmd.last = r_a_last;
    end

    assign o_cmd_push = r_a_valid && !i_cmd_full;
    assign o_cmd      = cmd;

endmodule

// ===== hdl/rpg_back.sv =====
// rpg_back: holds the permutation table and performs the swaps, one command
// at a time. Depends on rpg_pkg; reads the command queue, feeds the result queue.
`timescale 1ns / 1ps

module rpg_back #(
    parameter int MAX_CARDS = 1024,
    parameter int IDX_W     = $clog2(MAX_CARDS),
    parameter int CMD_W     = 2 * IDX_W + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output rpg_pkg::t_out      o_out,
    output logic               o_sweeping
);

    localparam int EW  = rpg_pkg::EPOCH_W;
    localparam int MW  = EW + IDX_W;

    typedef struct packed {
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             clr;
        logic             last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_READ  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    logic [MW-1:0]    r_mem [MAX_CARDS];
    logic [MW-1:0]    r_rd_i, r_rd_j;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_sweep_cnt, n_sweep_cnt;
    logic [EW-1:0]    r_epoch, n_epoch;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_addr, n_pend_addr;
    logic [IDX_W-1:0] r_pend_val, n_pend_val;
    t_cmd             r_cur;
    logic             r_fwd_i, r_fwd_j;
    logic [IDX_W-1:0] r_fwd_val;

    t_cmd             head;
    logic             can_go;
    logic             issue;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [MW-1:0]    mem_wd;
    logic [IDX_W-1:0] val_a, val_b;

    assign head   = i_cmd;
    assign can_go = (r_state == S_READ) && !i_cmd_empty && !i_out_full;
    // epoch tag exhausted: sweep the tags before this clear can take effect
    assign issue  = can_go && !(head.clr && (r_epoch == rpg_pkg::EPOCH_LAST));

    assign o_cmd_pop  = issue;
    assign o_sweeping = (r_state == S_SWEEP);

    // stale tag means the entry still reads as its own index
    always_comb begin
        if (r_fwd_i) begin
            val_a = r_fwd_val;
        end else if (r_rd_i[MW-1:IDX_W] == r_epoch) begin
            val_a = r_rd_i[IDX_W-1:0];
        end else begin
            val_a = r_cur.i;
        end
        if (r_fwd_j) begin
            val_b = r_fwd_val;
        end else if (r_rd_j[MW-1:IDX_W] == r_epoch) begin
            val_b = r_rd_j[IDX_W-1:0];
        end else begin
            val_b = r_cur.j;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sweep_cnt = r_sweep_cnt;
        n_epoch     = r_epoch;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_pend_val  = r_pend_val;
        mem_we      = 1'b0;
        mem_wa      = r_pend_addr;
        mem_wd      = {r_epoch, r_pend_val};
        o_out_push  = 1'b0;
        o_out.card  = 10'(val_b);
        o_out.last  = r_cur.last;
        unique case (r_state)
            S_SWEEP: begin
                mem_we      = 1'b1;
                mem_wa      = r_sweep_cnt;
                mem_wd      = '0;
                n_sweep_cnt = r_sweep_cnt + IDX_W'(1);
                if (r_sweep_cnt == IDX_W'(MAX_CARDS - 1)) begin
                    n_epoch = rpg_pkg::EPOCH_FIRST;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // second write of the previous swap shares the cycle with the reads
                mem_we = r_pend;
                n_pend = 1'b0;
                if (issue) begin
                    if (head.clr) begin
                        n_epoch = r_epoch + EW'(1);
                    end
                    n_state = S_WRITE;
                end else if (can_go) begin
                    n_sweep_cnt = '0;
                    n_state     = S_SWEEP;
                end
            end
            S_WRITE: begin
                mem_we      = 1'b1;
                mem_wa      = r_cur.j;
                mem_wd      = {r_epoch, val_a};
                o_out_push  = 1'b1;
                n_pend      = 1'b1;
                n_pend_addr = r_cur.i;
                n_pend_val  = val_b;
                n_state     = S_READ;
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_cnt <= '0;
            r_epoch     <= rpg_pkg::EPOCH_FIRST;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_cnt <= n_sweep_cnt;
            r_epoch     <= n_epoch;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_pend_val  <= n_pend_val;
        if (issue) begin
            r_cur     <= head;
            r_fwd_i   <= r_pend && !head.clr && (head.i == r_pend_addr);
            r_fwd_j   <= r_pend && !head.clr && (head.j == r_pend_addr);
            r_fwd_val <= r_pend_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (issue) begin
            r_rd_i <= r_mem[head.i];
            r_rd_j <= r_mem[head.j];
        end
    end

endmodule

// ===== bench/rpg_shuffle_checker.sv =====
// rpg_shuffle_checker: watches the item, result and APB channels of the
// permutation generator, predicts every card and compares. Depends on rpg_pkg.
`timescale 1ns / 1ps

module rpg_shuffle_checker #(
    parameter int         MAX_CARDS = 1024,
    parameter logic [2:0] LEN_ADDR  = 3'd0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  rpg_pkg::t_in  i_item,
    input  logic          i_empty,
    input  logic          i_pop,
    input  rpg_pkg::t_out i_result,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    input  logic [31:0]   i_prdata,
    input  logic          i_pready,
    output int            o_mismatches,
    output int            o_pending
);

    localparam int CW = rpg_pkg::CARD_COUNT_W;

    logic [9:0]           deck [MAX_CARDS];
    logic [MAX_CARDS-1:0] dealt;        // entry holds a swapped value
    int unsigned          cursor;
    logic [CW-1:0]        card_count;
    rpg_pkg::t_out        cards_due [$];
    int                   mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void wipe_deck();
        dealt  = '0;
        cursor = 0;
    endfunction

    function automatic logic [9:0] card_at(input int unsigned idx);
        return dealt[idx] ? deck[idx] : idx[9:0];
    endfunction

    // one forward Fisher-Yates step
    function automatic rpg_pkg::t_out deal_card(input rpg_pkg::t_in beat);
        int unsigned   n;
        int unsigned   i;
        int unsigned   j;
        logic [63:0]   prod;
        logic [9:0]    a;
        logic [9:0]    b;
        rpg_pkg::t_out res;
        if (card_count == 0)
            n = 1;
        else if (card_count > MAX_CARDS)
            n = MAX_CARDS;
        else
            n = card_count;
        // a shrunk length leaves the cursor past the end: start afresh
        if (beat.restart || cursor >= n)
            wipe_deck();
        i    = cursor;
        prod = 64'(beat.random_word) * 64'(n - i);
        j    = i + prod[63:32];
        if (j >= n)
            j = n - 1;
        a = card_at(i);
        b = card_at(j);
        deck[i]  = b;
        dealt[i] = 1'b1;
        deck[j]  = a;
        dealt[j] = 1'b1;
        res.card = b;
        res.last = (i == n - 1);
        if (res.last)
            wipe_deck();
        else
            cursor = i + 1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        rpg_pkg::t_out want;
        if (!i_rst_n) begin
            wipe_deck();
            card_count = CW'(rpg_pkg::CARD_COUNT_RST);
            cards_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == LEN_ADDR) begin
                if (i_pwrite)
                    card_count = i_pwdata[CW-1:0];
                else if (i_prdata[CW-1:0] !== card_count)
                    report_mismatch("length readback", i_prdata[CW-1:0], card_count);
            end
            if (i_pop && !i_empty) begin
                if (cards_due.size() == 0) begin
                    report_mismatch("card with none due", i_result.card, -1);
                end else begin
                    want = cards_due.pop_front();
                    if (i_result.card !== want.card)
                        report_mismatch("card", i_result.card, want.card);
                    if (i_result.last !== want.last)
                        report_mismatch("last", i_result.last, want.last);
                end
            end
            if (i_push && !i_full)
                cards_due.push_back(deal_card(i_item));
        end
        o_pending = cards_due.size();
    end

endmodule

// ===== bench/random_permutation_generator_unit_test.sv =====
// random_permutation_generator_unit_test: stimulus, idling and verdict for the
// shuffle block. Depends on rpg_pkg, the block and rpg_shuffle_checker.
`timescale 1ns / 1ps

module random_permutation_generator_unit_test;

    localparam logic [2:0] LEN_ADDR       = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam int         RANDOM_ITEMS   = 170;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         WATCHDOG_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    rpg_pkg::t_in  i_item;
    logic          empty;
    logic          pop;
    rpg_pkg::t_out o_result;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    logic          steady;      // no idling on either side
    int            mismatches;
    int            pending;
    int            stalled;

    random_permutation_generator_unit dut (
        .i_clk, .i_rst_n, .push, .full, .i_item, .empty, .pop, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    rpg_shuffle_checker #(.LEN_ADDR(LEN_ADDR)) u_checker (
        .i_clk, .i_rst_n,
        .i_push(push), .i_full(full), .i_item,
        .i_empty(empty), .i_pop(pop), .i_result(o_result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_prdata(prdata), .i_pready(pready),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        pop <= steady || ($urandom_range(0, 99) >= 28);
    end

    // entered and left at a falling edge; push stays high after the beat
    task automatic push_beat(input logic [31:0] word, input logic rs);
        while (!steady && $urandom_range(0, 99) < 28) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= {word, rs};
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // biased towards the ends of the range
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            3: return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty))
                stalled = 0;
            else
                stalled++;
        end
        $display("random_permutation_generator_unit verification failed");
        $finish;
    end

    initial begin
        int          n_items;
        int          len;
        int          burst;
        int          sel;
        logic [31:0] setting;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        steady  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full length from reset: smallest and largest picks, restart
        apb_access(1'b0, LEN_ADDR, '0);
        push_beat(32'h0000_0000, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h5555_5555, 1'b0);
        push_beat(32'hAAAA_AAAA, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1);
        push_beat(32'h0000_0001, 1'b0);
        settle();
        // shrink below the current position
        apb_access(1'b1, LEN_ADDR, 32'd2);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0000, 1'b0);
        push_beat(32'h0000_0000, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b1);
        settle();
        // zero length behaves as one
        apb_access(1'b1, LEN_ADDR, 32'd0);
        apb_access(1'b0, LEN_ADDR, '0);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0000, 1'b1);
        push_beat(32'h1234_5678, 1'b0);
        settle();
        apb_access(1'b1, LEN_ADDR, 32'd1);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h8000_0000, 1'b0);
        settle();
        // other index ignored; upper data bits dropped; oversize clamps
        apb_access(1'b1, ADDR_UNUSED, 32'd5);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0000, 1'b0);
        settle();
        apb_access(1'b1, LEN_ADDR, 32'hFFFF_FFFF);
        apb_access(1'b0, LEN_ADDR, '0);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0000, 1'b0);
        settle();

        // largest size, back to back: ends the permutation under way and starts the next
        apb_access(1'b1, LEN_ADDR, 32'd1024);
        steady <= 1'b1;
        repeat (1024 + 3) push_beat(pick_word(), 1'b0);
        steady <= 1'b0;

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            settle();
            sel = $urandom_range(0, 99);
            if (sel < 6)
                len = 0;
            else if (sel < 12)
                len = 1;
            else if (sel < 18)
                len = 2;
            else if (sel < 22)
                len = $urandom_range(1000, 2047);
            else if (sel < 30)
                len = $urandom_range(65, 1023);
            else
                len = $urandom_range(3, 64);
            setting = ($urandom & ~32'h7FF) | 32'(len);
            apb_access(1'b1, LEN_ADDR, setting);
            if ($urandom_range(0, 3) == 0)
                apb_access(1'b0, LEN_ADDR, '0);
            if ($urandom_range(0, 9) == 0)
                apb_access(1'b1, ADDR_UNUSED, $urandom);
            burst = $urandom_range(1, 120);
            repeat (burst) begin
                if ($urandom_range(0, 199) == 0)
                    settle();
                push_beat(pick_word(), $urandom_range(0, 49) == 0);
                n_items++;
            end
        end
        settle();

        if (mismatches == 0)
            $display("random_permutation_generator_unit verification clean");
        else
            $display("random_permutation_generator_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rpg_pkg.sv
hdl/rpg_fifo.sv
hdl/rpg_front.sv
hdl/rpg_back.sv
hdl/random_permutation_generator_unit.sv
bench/rpg_shuffle_checker.sv
bench/random_permutation_generator_unit_test.sv
